// ===== rtl/dsfr_pkg.sv =====
package dsfr_pkg;

    // Frame receive phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_PAD1,
        PH_IDS,
        PH_PAD2,
        PH_TIME,
        PH_DATA
    } phase_t;

    // Result kinds, carried on m_tuser
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_OTHER   = 2'd2,
        KIND_TRUNC   = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_STATION_ID = 2'd0,
        REG_ESCAPE     = 2'd1,
        REG_START      = 2'd2,
        REG_END        = 2'd3
    } cfg_reg_t;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] STATION_ID_RESET = 32'd123131;
    localparam logic [7:0]  ESCAPE_RESET     = 8'd16;
    localparam logic [7:0]  START_RESET      = 8'd2;
    localparam logic [7:0]  END_RESET        = 8'd3;

    localparam int unsigned LEN_W        = 12;
    localparam int unsigned HDR_CNT_W    = 5;
    localparam int unsigned RESULT_BITS  = 8 + 32 + LEN_W + 64 + 64;
    localparam int unsigned TDATA_W      = ((RESULT_BITS + 7) / 8) * 8;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic signed [31:0] source_id;
        logic [LEN_W-1:0]   frame_length;
        logic signed [63:0] sent_seconds;
        logic signed [63:0] sent_micros;
        logic               last;
    } result_t;

    // Handshake between the stages
    typedef struct packed {
        logic step;      // core consumes the held word this cycle
        logic can_load;  // output register is free or being drained
    } flow_t;

endpackage

// ===== rtl/dsfr_in_stage.sv =====
module dsfr_in_stage (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        can_load,
    output logic        step,
    output logic [7:0]  byte_out
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !in_valid_reg || can_load;
    assign step     = in_valid_reg && can_load;
    assign byte_out = byte_reg;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold the word until the core takes it
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

// ===== rtl/dsfr_core.sv =====
module dsfr_core #(
    parameter int unsigned MAX_PAYLOAD    = 2048,
    parameter int unsigned PAD_BEFORE_IDS = 2,
    parameter int unsigned PAD_AFTER_IDS  = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dsfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            step,
    input  logic [7:0]                      rx_byte,
    output logic                            res_valid,
    output dsfr_pkg::result_t               res
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned HW    = dsfr_pkg::HDR_CNT_W;

    // configuration
    logic [31:0] station_id_reg;
    logic [7:0]  escape_reg, start_reg, end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_id_reg <= dsfr_pkg::STATION_ID_RESET;
            escape_reg     <= dsfr_pkg::ESCAPE_RESET;
            start_reg      <= dsfr_pkg::START_RESET;
            end_reg        <= dsfr_pkg::END_RESET;
        end else if (cfg_wr_en) begin
            case (dsfr_pkg::cfg_reg_t'(cfg_addr))
                dsfr_pkg::REG_STATION_ID: station_id_reg <= cfg_wdata;
                dsfr_pkg::REG_ESCAPE:     escape_reg     <= cfg_wdata[7:0];
                dsfr_pkg::REG_START:      start_reg      <= cfg_wdata[7:0];
                dsfr_pkg::REG_END:        end_reg        <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // state
    dsfr_pkg::phase_t phase_reg, phase_next;
    logic             esc_reg, esc_next;
    logic [HW-1:0]    hc_reg, hc_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [63:0]      sec_reg, sec_next;
    logic [63:0]      usec_reg, usec_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // decode
    logic [HW-1:0]    hc_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic             start_hit, pad1_done, ids_done, dest_match, pad2_done, time_done;
    logic             data_end, data_deliver, limit_hit;
    logic [31:0]      dst_full;
    logic [CNT_W+dsfr_pkg::LEN_W-1:0] len_inc_wide, len_cur_wide;

    always_comb begin
        hc_inc       = hc_reg + HW'(1);
        cnt_inc      = cnt_reg + CNT_W'(1);
        dst_full     = {rx_byte, dst_reg[23:0]};
        start_hit    = (phase_reg == dsfr_pkg::PH_HUNT) && esc_reg && (rx_byte == start_reg);
        pad1_done    = (phase_reg == dsfr_pkg::PH_PAD1) && (hc_inc >= HW'(PAD_BEFORE_IDS));
        ids_done     = (phase_reg == dsfr_pkg::PH_IDS) && (hc_inc >= HW'(8));
        dest_match   = (dst_full == station_id_reg);
        pad2_done    = (phase_reg == dsfr_pkg::PH_PAD2) && (hc_inc >= HW'(PAD_AFTER_IDS));
        time_done    = (phase_reg == dsfr_pkg::PH_TIME) && (hc_inc >= HW'(16));
        data_end     = (phase_reg == dsfr_pkg::PH_DATA) && esc_reg && (rx_byte == end_reg);
        data_deliver = (phase_reg == dsfr_pkg::PH_DATA) &&
                       (esc_reg ? (rx_byte != end_reg) : (rx_byte != escape_reg));
        limit_hit    = data_deliver && (cnt_inc >= CNT_W'(MAX_PAYLOAD));
        len_inc_wide = {{dsfr_pkg::LEN_W{1'b0}}, cnt_inc};
        len_cur_wide = {{dsfr_pkg::LEN_W{1'b0}}, cnt_reg};
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            dsfr_pkg::PH_HUNT: begin
                if (start_hit) begin
                    phase_next = (PAD_BEFORE_IDS == 0) ? dsfr_pkg::PH_IDS : dsfr_pkg::PH_PAD1;
                end
            end
            dsfr_pkg::PH_PAD1: begin
                if (pad1_done) phase_next = dsfr_pkg::PH_IDS;
            end
            dsfr_pkg::PH_IDS: begin
                if (ids_done) begin
                    if (!dest_match) begin
                        phase_next = dsfr_pkg::PH_HUNT;
                    end else begin
                        phase_next = (PAD_AFTER_IDS == 0) ? dsfr_pkg::PH_TIME
                                                          : dsfr_pkg::PH_PAD2;
                    end
                end
            end
            dsfr_pkg::PH_PAD2: begin
                if (pad2_done) phase_next = dsfr_pkg::PH_TIME;
            end
            dsfr_pkg::PH_TIME: begin
                if (time_done) phase_next = dsfr_pkg::PH_DATA;
            end
            dsfr_pkg::PH_DATA: begin
                if (data_end || limit_hit) phase_next = dsfr_pkg::PH_HUNT;
            end
            default: phase_next = dsfr_pkg::PH_HUNT;
        endcase
    end

    // datapath next values
    always_comb begin
        esc_next  = esc_reg;
        hc_next   = hc_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        sec_next  = sec_reg;
        usec_next = usec_reg;
        cnt_next  = cnt_reg;
        case (phase_reg)
            dsfr_pkg::PH_HUNT: begin
                if (start_hit) begin
                    src_next  = '0;
                    dst_next  = '0;
                    sec_next  = '0;
                    usec_next = '0;
                    hc_next   = '0;
                end else begin
                    esc_next = (rx_byte == escape_reg);
                end
            end
            dsfr_pkg::PH_PAD1, dsfr_pkg::PH_PAD2: begin
                hc_next = (pad1_done || pad2_done) ? '0 : hc_inc;
            end
            dsfr_pkg::PH_IDS: begin
                if (!hc_reg[2]) begin
                    src_next[8*hc_reg[1:0] +: 8] = rx_byte;
                end else begin
                    dst_next[8*hc_reg[1:0] +: 8] = rx_byte;
                end
                hc_next = ids_done ? '0 : hc_inc;
                if (ids_done && !dest_match) esc_next = 1'b0;
            end
            dsfr_pkg::PH_TIME: begin
                if (!hc_reg[3]) begin
                    sec_next[8*hc_reg[2:0] +: 8] = rx_byte;
                end else begin
                    usec_next[8*hc_reg[2:0] +: 8] = rx_byte;
                end
                hc_next = time_done ? '0 : hc_inc;
                if (time_done) begin
                    cnt_next = '0;
                    esc_next = 1'b0;
                end
            end
            dsfr_pkg::PH_DATA: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (rx_byte == escape_reg) begin
                    esc_next = 1'b1;
                end
                if (data_deliver) cnt_next = cnt_inc;
                if (limit_hit) esc_next = 1'b0;
                hc_next = '0;
            end
            default: begin
                hc_next  = '0;
                esc_next = 1'b0;
            end
        endcase
    end

    // result
    always_comb begin
        res_valid        = 1'b0;
        res.kind         = dsfr_pkg::KIND_PAYLOAD;
        res.data         = rx_byte;
        res.source_id    = src_reg;
        res.frame_length = len_inc_wide[dsfr_pkg::LEN_W-1:0];
        res.sent_seconds = sec_reg;
        res.sent_micros  = usec_reg;
        res.last         = 1'b0;
        case (phase_reg)
            dsfr_pkg::PH_IDS: begin
                if (ids_done && !dest_match) begin
                    res_valid        = step;
                    res.kind         = dsfr_pkg::KIND_OTHER;
                    res.data         = '0;
                    res.frame_length = '0;
                    res.sent_seconds = '0;
                    res.sent_micros  = '0;
                    res.last         = 1'b1;
                end
            end
            dsfr_pkg::PH_DATA: begin
                if (data_end) begin
                    res_valid        = step;
                    res.kind         = dsfr_pkg::KIND_END;
                    res.data         = '0;
                    res.frame_length = len_cur_wide[dsfr_pkg::LEN_W-1:0];
                    res.last         = 1'b1;
                end else if (data_deliver) begin
                    res_valid = step;
                    res.kind  = limit_hit ? dsfr_pkg::KIND_TRUNC : dsfr_pkg::KIND_PAYLOAD;
                    res.last  = limit_hit;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dsfr_pkg::PH_HUNT;
            esc_reg   <= 1'b0;
            hc_reg    <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sec_reg   <= '0;
            usec_reg  <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            hc_reg    <= hc_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            sec_reg   <= sec_next;
            usec_reg  <= usec_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_drop_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == dsfr_pkg::KIND_OTHER) |=> phase_reg == dsfr_pkg::PH_HUNT)
        else $error("frame for other station did not resume hunting");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == dsfr_pkg::PH_DATA) |-> (cnt_reg < CNT_W'(MAX_PAYLOAD)))
        else $error("payload count reached the limit without closing the frame");

    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (phase_reg == dsfr_pkg::PH_IDS) || (phase_reg == dsfr_pkg::PH_DATA))
        else $error("result raised outside address check or payload");

    a_truncate_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.kind == dsfr_pkg::KIND_TRUNC) |=>
        (phase_reg == dsfr_pkg::PH_HUNT) && !esc_reg)
        else $error("truncated frame did not rearm the start detector");

endmodule

// ===== rtl/dsfr_out_reg.sv =====
module dsfr_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         res_valid,
    input  dsfr_pkg::result_t            res,
    output logic                         can_load,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dsfr_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    logic              out_valid_reg, out_valid_next;
    dsfr_pkg::result_t out_reg;

    assign can_load = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = can_load ? res_valid : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = dsfr_pkg::TDATA_W'({out_reg.sent_micros, out_reg.sent_seconds,
                                          out_reg.frame_length, out_reg.source_id,
                                          out_reg.data});

endmodule

// ===== rtl/dle_stuffed_frame_receiver.sv =====
// DLE/STX ... DLE/ETX byte-stuffed frame receiver.
//
// Feed one received link byte per word on the s_ channel. The receiver hunts for the
// escape/start pair, skips pad bytes, reads the source and destination IDs, drops
// frames addressed elsewhere (one kind-2 word), reads the 16-byte timestamp, and then
// emits one m_ word per unstuffed payload byte. An escape followed by the end code
// closes the frame with a kind-1 word; the MAX_PAYLOAD-th payload byte closes it as
// kind 3. Every closing word has m_tlast set. Header and escape bytes produce no word.
//
// A byte accepted on s_ passes the input register, then the state update feeding the
// result register that drives m_. While m_tready stays high, throughput is one byte
// per cycle, set by the combinational state update between the two registers.
// When m_tready is low while a result waits, the state update holds; the input
// register takes one more byte only if it is empty, and s_tready stays low until the
// result is taken.
// Reset (aresetn low, synchronous) empties both registers, puts the receiver back to
// hunting and restores the default codes and station ID. Write the cfg_ registers
// only while no byte is in flight.
module dle_stuffed_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD    = 2048,
    parameter int unsigned PAD_BEFORE_IDS = 2,
    parameter int unsigned PAD_AFTER_IDS  = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [dsfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // received bytes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] data, [39:8] source_id, [51:40] frame_length,
    // [115:52] sent_seconds, [179:116] sent_micros, [183:180] zero
    output logic [dsfr_pkg::TDATA_W-1:0]    m_tdata,
    output logic [1:0]                      m_tuser,   // [1:0] kind
    output logic                            m_tlast    // frame closed
);

    dsfr_pkg::flow_t   flow;
    logic [7:0]        byte_held;
    logic              res_valid;
    dsfr_pkg::result_t res;

    // hold one raw byte ahead of the state update
    dsfr_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .can_load (flow.can_load),
        .step     (flow.step),
        .byte_out (byte_held)
    );

    // advance the deframing state one byte per step
    dsfr_core #(
        .MAX_PAYLOAD    (MAX_PAYLOAD),
        .PAD_BEFORE_IDS (PAD_BEFORE_IDS),
        .PAD_AFTER_IDS  (PAD_AFTER_IDS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (flow.step),
        .rx_byte   (byte_held),
        .res_valid (res_valid),
        .res       (res)
    );

    // register the result and drive the master side
    dsfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (flow.can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== dv/dsfr_checker.sv =====
`timescale 1ns / 1ps

module dsfr_checker #(
    parameter int unsigned MAX_PAYLOAD    = 2048,
    parameter int unsigned PAD_BEFORE_IDS = 2,
    parameter int unsigned PAD_AFTER_IDS  = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dsfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dsfr_pkg::TDATA_W-1:0]    m_tdata,
    input  logic [1:0]                      m_tuser,
    input  logic                            m_tlast,
    output int                              words_outstanding,
    output int                              mismatch_count
);

    logic [31:0] station_id;
    logic [7:0]  escape_code;
    logic [7:0]  start_code;
    logic [7:0]  end_code;

    dsfr_pkg::phase_t rx_phase;
    logic        after_escape;
    int unsigned hdr_cnt;
    int unsigned pay_cnt;
    logic [31:0] src_id;
    logic [31:0] dst_id;
    logic [63:0] secs;
    logic [63:0] usec;

    dsfr_pkg::result_t words_due[$];
    int          n_mismatch = 0;
    int          n_due      = 0;

    assign mismatch_count    = n_mismatch;
    assign words_outstanding = n_due;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        n_mismatch++;
    endtask

    task automatic enter_phase(input dsfr_pkg::phase_t next);
        dsfr_pkg::phase_t nxt;
        nxt     = next;
        hdr_cnt = 0;
        if (nxt == dsfr_pkg::PH_PAD1 && PAD_BEFORE_IDS == 0)
            nxt = dsfr_pkg::PH_IDS;
        if (nxt == dsfr_pkg::PH_PAD2 && PAD_AFTER_IDS == 0)
            nxt = dsfr_pkg::PH_TIME;
        if (nxt == dsfr_pkg::PH_DATA) begin
            pay_cnt      = 0;
            after_escape = 1'b0;
        end
        if (nxt == dsfr_pkg::PH_HUNT)
            after_escape = 1'b0;
        rx_phase = nxt;
    endtask

    task automatic post(input dsfr_pkg::kind_t k, input logic [7:0] d,
                        input logic [dsfr_pkg::LEN_W-1:0] len,
                        input logic [63:0] s, input logic [63:0] u, input logic lst);
        dsfr_pkg::result_t r;
        r.kind         = k;
        r.data         = d;
        r.source_id    = src_id;
        r.frame_length = len;
        r.sent_seconds = s;
        r.sent_micros  = u;
        r.last         = lst;
        words_due.push_back(r);
    endtask

    task automatic deliver(input logic [7:0] b);
        pay_cnt++;
        if (pay_cnt >= MAX_PAYLOAD) begin
            post(dsfr_pkg::KIND_TRUNC, b, dsfr_pkg::LEN_W'(pay_cnt), secs, usec, 1'b1);
            enter_phase(dsfr_pkg::PH_HUNT);
        end else begin
            post(dsfr_pkg::KIND_PAYLOAD, b, dsfr_pkg::LEN_W'(pay_cnt), secs, usec, 1'b0);
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        case (rx_phase)
            dsfr_pkg::PH_HUNT: begin
                if (after_escape && b == start_code) begin
                    src_id = '0;
                    dst_id = '0;
                    secs   = '0;
                    usec   = '0;
                    enter_phase(dsfr_pkg::PH_PAD1);
                end else begin
                    after_escape = (b == escape_code);
                end
            end
            dsfr_pkg::PH_PAD1: begin
                hdr_cnt++;
                if (hdr_cnt >= PAD_BEFORE_IDS)
                    enter_phase(dsfr_pkg::PH_IDS);
            end
            dsfr_pkg::PH_IDS: begin
                if (hdr_cnt < 4)
                    src_id[8*(hdr_cnt%4) +: 8] = b;
                else
                    dst_id[8*(hdr_cnt%4) +: 8] = b;
                hdr_cnt++;
                if (hdr_cnt >= 8) begin
                    if (dst_id != station_id) begin
                        post(dsfr_pkg::KIND_OTHER, '0, '0, '0, '0, 1'b1);
                        enter_phase(dsfr_pkg::PH_HUNT);
                    end else begin
                        enter_phase(dsfr_pkg::PH_PAD2);
                    end
                end
            end
            dsfr_pkg::PH_PAD2: begin
                hdr_cnt++;
                if (hdr_cnt >= PAD_AFTER_IDS)
                    enter_phase(dsfr_pkg::PH_TIME);
            end
            dsfr_pkg::PH_TIME: begin
                if (hdr_cnt < 8)
                    secs[8*(hdr_cnt%8) +: 8] = b;
                else
                    usec[8*(hdr_cnt%8) +: 8] = b;
                hdr_cnt++;
                if (hdr_cnt >= 16)
                    enter_phase(dsfr_pkg::PH_DATA);
            end
            dsfr_pkg::PH_DATA: begin
                if (after_escape) begin
                    after_escape = 1'b0;
                    if (b == end_code) begin
                        post(dsfr_pkg::KIND_END, '0, dsfr_pkg::LEN_W'(pay_cnt), secs, usec,
                             1'b1);
                        enter_phase(dsfr_pkg::PH_HUNT);
                    end else begin
                        deliver(b);
                    end
                end else if (b == escape_code) begin
                    after_escape = 1'b1;
                end else begin
                    deliver(b);
                end
            end
            default: enter_phase(dsfr_pkg::PH_HUNT);
        endcase
    endtask

    task automatic check_word();
        dsfr_pkg::result_t got;
        dsfr_pkg::result_t want;
        got.kind         = dsfr_pkg::kind_t'(m_tuser);
        got.data         = m_tdata[7:0];
        got.source_id    = m_tdata[39:8];
        got.frame_length = m_tdata[51:40];
        got.sent_seconds = m_tdata[115:52];
        got.sent_micros  = m_tdata[179:116];
        got.last         = m_tlast;
        if (words_due.size() == 0) begin
            flag_mismatch("word with none due, kind", got.kind, '0);
        end else begin
            want = words_due.pop_front();
            if (got.kind != want.kind)
                flag_mismatch("kind", got.kind, want.kind);
            if (got.data != want.data)
                flag_mismatch("data", got.data, want.data);
            if (got.source_id != want.source_id)
                flag_mismatch("source_id", got.source_id, want.source_id);
            if (got.frame_length != want.frame_length)
                flag_mismatch("frame_length", got.frame_length, want.frame_length);
            if (got.sent_seconds != want.sent_seconds)
                flag_mismatch("sent_seconds", got.sent_seconds, want.sent_seconds);
            if (got.sent_micros != want.sent_micros)
                flag_mismatch("sent_micros", got.sent_micros, want.sent_micros);
            if (got.last != want.last)
                flag_mismatch("last", got.last, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            station_id   = dsfr_pkg::STATION_ID_RESET;
            escape_code  = dsfr_pkg::ESCAPE_RESET;
            start_code   = dsfr_pkg::START_RESET;
            end_code     = dsfr_pkg::END_RESET;
            rx_phase     = dsfr_pkg::PH_HUNT;
            after_escape = 1'b0;
            hdr_cnt      = 0;
            pay_cnt      = 0;
            src_id       = '0;
            dst_id       = '0;
            secs         = '0;
            usec         = '0;
            words_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_word();
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (cfg_wr_en) begin
                case (dsfr_pkg::cfg_reg_t'(cfg_addr))
                    dsfr_pkg::REG_STATION_ID: station_id  = cfg_wdata[31:0];
                    dsfr_pkg::REG_ESCAPE:     escape_code = cfg_wdata[7:0];
                    dsfr_pkg::REG_START:      start_code  = cfg_wdata[7:0];
                    dsfr_pkg::REG_END:        end_code    = cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        n_due = words_due.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned MAX_PAYLOAD    = 2048;
    localparam int unsigned PAD_BEFORE_IDS = 2;
    localparam int unsigned PAD_AFTER_IDS  = 4;

    // bytes carried inside frames across the random part, split over six code settings
    localparam int RANDOM_BYTES  = 950;
    localparam int SETTINGS_RUN  = 6;
    // cycles to wait after the last due word: two register stages plus margin
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 300000;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [dsfr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [dsfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;   // [7:0] rx_byte
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // [7:0] data, [39:8] source_id, [51:40] frame_length,
    // [115:52] sent_seconds, [179:116] sent_micros
    logic [dsfr_pkg::TDATA_W-1:0]    m_tdata;
    logic [1:0]                      m_tuser;          // [1:0] kind
    logic                            m_tlast;

    int words_outstanding;
    int mismatch_count;

    // idle rates in percent for the link side and the result side
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // codes as last programmed, used to build frames
    logic [31:0] station  = dsfr_pkg::STATION_ID_RESET;
    logic [7:0]  esc_code = dsfr_pkg::ESCAPE_RESET;
    logic [7:0]  stx_code = dsfr_pkg::START_RESET;
    logic [7:0]  etx_code = dsfr_pkg::END_RESET;

    int frame_bytes = 0;
    int cycle_count = 0;

    dle_stuffed_frame_receiver #(
        .MAX_PAYLOAD    (MAX_PAYLOAD),
        .PAD_BEFORE_IDS (PAD_BEFORE_IDS),
        .PAD_AFTER_IDS  (PAD_AFTER_IDS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    dsfr_checker #(
        .MAX_PAYLOAD    (MAX_PAYLOAD),
        .PAD_BEFORE_IDS (PAD_BEFORE_IDS),
        .PAD_AFTER_IDS  (PAD_AFTER_IDS)
    ) u_chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .words_outstanding (words_outstanding),
        .mismatch_count    (mismatch_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: stall at random at the current rate, one fresh draw per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one link byte and hold it until the receiver takes it. Drop valid for
    // idle cycles first, one draw per cycle at the current sender idle rate; otherwise
    // keep it high so back-to-back words go out without a bubble.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Bytes that belong to a frame count toward the random budget; hunt noise does not.
    task automatic frame_byte(input logic [7:0] b);
        send_byte(b);
        frame_bytes++;
    endtask

    // Hold the link idle until every due word has come out, then let the pipeline
    // empty of bytes that produce nothing (header, pads, escapes).
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (words_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Rewrite all four code registers with the receiver idle.
    task automatic program_codes(input logic [31:0] sid, input logic [7:0] esc,
                                 input logic [7:0] stx, input logic [7:0] etx);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= dsfr_pkg::REG_STATION_ID;
        cfg_wdata <= sid;
        @(posedge aclk);
        cfg_addr  <= dsfr_pkg::REG_ESCAPE;
        cfg_wdata <= {24'd0, esc};
        @(posedge aclk);
        cfg_addr  <= dsfr_pkg::REG_START;
        cfg_wdata <= {24'd0, stx};
        @(posedge aclk);
        cfg_addr  <= dsfr_pkg::REG_END;
        cfg_wdata <= {24'd0, etx};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        station  = sid;
        esc_code = esc;
        stx_code = stx;
        etx_code = etx;
    endtask

    // Start pair, pads, IDs little endian; pads and timestamp only when the frame is
    // for this station, since the receiver drops the rest right after the IDs.
    task automatic send_header(input logic [31:0] src, input logic [31:0] dst,
                               input logic [63:0] secs, input logic [63:0] usec);
        int i;
        frame_byte(esc_code);
        frame_byte(stx_code);
        repeat (PAD_BEFORE_IDS) frame_byte(8'($urandom));
        for (i = 0; i < 4; i++) frame_byte(src[8*i +: 8]);
        for (i = 0; i < 4; i++) frame_byte(dst[8*i +: 8]);
        if (dst == station) begin
            repeat (PAD_AFTER_IDS) frame_byte(8'($urandom));
            for (i = 0; i < 8; i++) frame_byte(secs[8*i +: 8]);
            for (i = 0; i < 8; i++) frame_byte(usec[8*i +: 8]);
        end
    endtask

    // Random payload, stuffed: escape every escape byte and a few others at random.
    // Bias toward the code values so stuffing and bare end codes show up often.
    task automatic send_payload(input int n, input bit closed);
        logic [7:0] b;
        int i;
        for (i = 0; i < n; i++) begin
            b = 8'($urandom);
            case ($urandom_range(15))
                0: b = esc_code;
                1: b = etx_code;
                2: b = stx_code;
                default: ;
            endcase
            // with escape equal to end, a doubled escape closes the frame: steer away
            if (b == esc_code && esc_code == etx_code)
                b = b + 8'd1;
            if (b == esc_code || (b != etx_code && $urandom_range(9) == 0))
                frame_byte(esc_code);
            frame_byte(b);
        end
        if (closed) begin
            frame_byte(esc_code);
            frame_byte(etx_code);
        end
    endtask

    // Idle-line bytes that never arm the start detector.
    task automatic hunt_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            if (b == esc_code)
                b = ~b;
            send_byte(b);
        end
    endtask

    // One random link event: mostly good frames with random content, then dropped
    // frames, frames cut short in the header, and raw noise.
    task automatic random_frame();
        logic [31:0] dst;
        int pick;
        int n;
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0)
            hunt_noise($urandom_range(1, 6));
        if (pick < 72) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
            send_header($urandom, station, {$urandom, $urandom}, {$urandom, $urandom});
            send_payload(n, 1'b1);
        end else if (pick < 86) begin
            // near misses on one bit as well as unrelated addresses
            dst = $urandom_range(1) ? (station ^ (32'd1 << $urandom_range(31))) : $urandom;
            if (dst == station)
                dst = ~dst;
            send_header($urandom, dst, '0, '0);
        end else if (pick < 94) begin
            // start pair with a truncated or garbled header, then an end pair
            frame_byte(esc_code);
            frame_byte(stx_code);
            repeat ($urandom_range(1, 60)) frame_byte(8'($urandom));
            frame_byte(esc_code);
            frame_byte(etx_code);
        end else begin
            // raw line noise, escapes and start codes included
            repeat ($urandom_range(2, 10)) send_byte(8'($urandom));
        end
        // now and then hold the link until everything due has come out
        if ($urandom_range(49) == 0)
            settle();
    endtask

    initial begin
        int target;
        int k;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Era one: link idles a little, result side stalls a lot.
        tx_idle_pct = 16;
        rx_idle_pct = 67;

        // Escape ahead of the start pair: the detector rearms on the second escape.
        send_byte(esc_code);
        send_header(32'h8000_0000, station, 64'h8000_0000_0000_0000,
                    64'h7FFF_FFFF_FFFF_FFFF);
        frame_byte(8'h00);
        frame_byte(8'hFF);
        frame_byte(esc_code);  // stuffed escape
        frame_byte(esc_code);
        frame_byte(esc_code);  // escaped start code, taken as data
        frame_byte(stx_code);
        frame_byte(esc_code);  // any escaped value is data
        frame_byte(8'hFF);
        frame_byte(etx_code);  // bare end code is plain data
        frame_byte(esc_code);
        frame_byte(etx_code);

        // After a close the hunt starts disarmed; a non-escape in between disarms too.
        send_byte(stx_code);
        send_byte(esc_code);
        send_byte(8'h55);
        send_byte(stx_code);

        // Empty frame, then one for another station.
        send_header(32'h7FFF_FFFF, station, '0, '1);
        frame_byte(esc_code);
        frame_byte(etx_code);
        send_header(32'hFFFF_FFFF, ~station, '0, '0);

        // Escape equal to end code: a doubled escape closes the frame.
        program_codes(32'h8000_0000, 8'hFF, 8'h00, 8'hFF);
        send_header(32'h0000_0000, station, '1, '0);
        frame_byte(8'h00);
        frame_byte(8'hFE);
        frame_byte(esc_code);
        frame_byte(esc_code);

        // Random part: six code settings, two per idle era.
        frame_bytes = 0;
        for (k = 0; k < SETTINGS_RUN; k++) begin
            case (k)
                0: program_codes(dsfr_pkg::STATION_ID_RESET, dsfr_pkg::ESCAPE_RESET,
                                 dsfr_pkg::START_RESET, dsfr_pkg::END_RESET);
                1: program_codes(32'h8000_0000, 8'h00, 8'hFF, 8'h80);
                2: begin
                    // Era two: link idles a lot, result side stalls a little.
                    tx_idle_pct = 67;
                    rx_idle_pct = 16;
                    program_codes(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF);
                end
                3: program_codes(32'h7FFF_FFFF, 8'h7E, 8'h7E, 8'h01);
                4: begin
                    // Era three: no idling on either side.
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    program_codes($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
                end
                default: program_codes(32'h0000_0000, 8'h10, 8'h02, 8'h03);
            endcase
            target = ((k + 1) * RANDOM_BYTES) / SETTINGS_RUN;
            while (frame_bytes < target)
                random_frame();
        end

        // Payload limit: one long frame runs into truncation; the tail is hunt noise.
        program_codes(32'h0001_E0FB, dsfr_pkg::ESCAPE_RESET, dsfr_pkg::START_RESET,
                      dsfr_pkg::END_RESET);
        send_header($urandom, station, {$urandom, $urandom}, {$urandom, $urandom});
        send_payload(MAX_PAYLOAD + 2, 1'b1);

        settle();
        if (mismatch_count == 0 && words_outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dsfr_pkg.sv
rtl/dsfr_in_stage.sv
rtl/dsfr_core.sv
rtl/dsfr_out_reg.sv
rtl/dle_stuffed_frame_receiver.sv
dv/dsfr_checker.sv
dv/tb.sv
